>>> rtl/annexb_pkg.sv
// Package with constants and types for the Annex B start-code splitter.
package annexb_pkg;

  // Unit and buffer limits
  localparam int unsigned MAX_NALUS        = 128;
  localparam int unsigned MAX_BUFFER_BYTES = 1048576;

  // Field and state widths
  localparam int unsigned POS_W    = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int unsigned OFFSET_W = 20;
  localparam int unsigned SIZE_W   = 21;
  localparam int unsigned SCLEN_W  = 3;
  localparam int unsigned NUMBER_W = 7;
  localparam int unsigned COUNT_W  = $clog2(MAX_NALUS + 1);

  // Start-code lengths
  localparam logic [SCLEN_W-1:0] SCLEN_SHORT = SCLEN_W'(3);
  localparam logic [SCLEN_W-1:0] SCLEN_LONG  = SCLEN_W'(4);

  // Output queue depth
  localparam int unsigned QDEPTH = 3;
  localparam int unsigned QIDX_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One NAL descriptor
  typedef struct packed {
    logic                nal_valid;
    logic [OFFSET_W-1:0] nal_offset;
    logic [SIZE_W-1:0]   nal_size;
    logic [SCLEN_W-1:0]  start_code_len;
    logic [NUMBER_W-1:0] nal_number;
    logic                buffer_final;
    logic                run_last;
  } nal_desc_t;

endpackage

>>> rtl/annexb_nal_unit_splitter_core.sv
// Annex B start-code splitter: scans buffer bytes and reports NAL unit descriptors.
// Descriptors wait in a three-entry output queue, which drains one per cycle while
// out_tready is high. Throughput: one byte per cycle while the queue holds at most
// one descriptor; a byte that causes two descriptors may stall input.
// Reset (rst_n low, synchronous) clears the parser state and empties the output queue;
// the parser state also clears by itself after every byte marked last.
module annexb_nal_unit_splitter_core
  import annexb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // last_byte
  // Descriptor stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // [19:0] nal_offset, [40:20] nal_size,
                                  // [43:41] start_code_len, [50:44] nal_number, rest 0
  output logic [1:0]  out_tuser,  // [0] nal_valid, [1] buffer_final
  output logic        out_tlast   // run_last
);

  // Parser state
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [1:0]          zrun_r, zrun_nxt;
  logic                open_r, open_nxt;
  logic [OFFSET_W-1:0] open_off_r, open_off_nxt;
  logic [SCLEN_W-1:0]  open_len_r, open_len_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;

  // Output queue, head in slot 0
  nal_desc_t           q_r [QDEPTH];
  nal_desc_t           q_nxt [QDEPTH];
  logic [QCNT_W-1:0]   qcnt_r, qcnt_nxt;

  logic                in_xfer, out_xfer;
  logic                pos_ok, is_zero, is_sc, emit_mid;
  logic [POS_W-1:0]    pos_inc;
  logic [SCLEN_W-1:0]  sclen;
  logic [POS_W-1:0]    code_start;
  nal_desc_t           mid_desc, fin_desc, push0, push1;
  logic [1:0]          npush;
  logic [QCNT_W-1:0]   base;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign in_tready = (qcnt_r <= QCNT_W'(1));

  // Decode the byte against the current state
  always_comb begin
    pos_ok     = (pos_r < POS_W'(MAX_BUFFER_BYTES));
    pos_inc    = pos_r + POS_W'(1);
    is_zero    = (in_tdata == 8'h00);
    sclen      = (zrun_r == 2'd3) ? SCLEN_LONG : SCLEN_SHORT;
    code_start = pos_inc - POS_W'(sclen);
    is_sc      = pos_ok && (in_tdata == 8'h01) && (zrun_r >= 2'd2)
                 && (cnt_r < COUNT_W'(MAX_NALUS))
                 && (pos_inc < POS_W'(MAX_BUFFER_BYTES));
    emit_mid   = is_sc && open_r;
  end

  // Advance the parser state
  always_comb begin
    pos_nxt      = pos_r;
    zrun_nxt     = zrun_r;
    open_nxt     = open_r;
    open_off_nxt = open_off_r;
    open_len_nxt = open_len_r;
    cnt_nxt      = cnt_r;
    if (pos_ok) begin
      pos_nxt = pos_inc;
      if (is_zero) begin
        if (zrun_r != 2'd3) zrun_nxt = zrun_r + 2'd1;
      end else begin
        zrun_nxt = 2'd0;
      end
    end
    if (is_sc) begin
      open_nxt     = 1'b1;
      open_off_nxt = pos_inc[OFFSET_W-1:0];
      open_len_nxt = sclen;
      cnt_nxt      = cnt_r + COUNT_W'(1);
    end
  end

  // Build the descriptors caused by this byte
  always_comb begin
    logic [COUNT_W-1:0] num_mid, num_fin;
    logic [POS_W-1:0]   sz_mid, sz_fin;
    num_mid = cnt_r - COUNT_W'(1);
    num_fin = cnt_nxt - COUNT_W'(1);
    sz_mid  = code_start - POS_W'(open_off_r);
    sz_fin  = pos_nxt - POS_W'(open_off_nxt);

    mid_desc.nal_valid      = 1'b1;
    mid_desc.nal_offset     = open_off_r;
    mid_desc.nal_size       = sz_mid[SIZE_W-1:0];
    mid_desc.start_code_len = open_len_r;
    mid_desc.nal_number     = num_mid[NUMBER_W-1:0];
    mid_desc.buffer_final   = 1'b0;
    mid_desc.run_last       = !in_tlast;

    fin_desc.nal_valid      = open_nxt;
    fin_desc.nal_offset     = open_nxt ? open_off_nxt : '0;
    fin_desc.nal_size       = open_nxt ? sz_fin[SIZE_W-1:0] : '0;
    fin_desc.start_code_len = open_nxt ? open_len_nxt : '0;
    fin_desc.nal_number     = open_nxt ? num_fin[NUMBER_W-1:0] : '0;
    fin_desc.buffer_final   = 1'b1;
    fin_desc.run_last       = 1'b1;

    push0 = emit_mid ? mid_desc : fin_desc;
    push1 = fin_desc;
    npush = {1'b0, emit_mid} + {1'b0, in_tlast};
  end

  // Pop the head, then append the new descriptors
  always_comb begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
      if (out_xfer) q_nxt[i] = (i + 1 < QDEPTH) ? q_r[(i + 1) % QDEPTH] : q_r[i];
    end
    base = qcnt_r - QCNT_W'(out_xfer);
    if (in_xfer && npush != 2'd0) q_nxt[base[QIDX_W-1:0]] = push0;
    if (in_xfer && npush == 2'd2) q_nxt[base[QIDX_W-1:0] + QIDX_W'(1)] = push1;
    qcnt_nxt = base + (in_xfer ? QCNT_W'(npush) : QCNT_W'(0));
  end

  // Hold or update the parser state and queue count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      zrun_r     <= '0;
      open_r     <= 1'b0;
      open_off_r <= '0;
      open_len_r <= '0;
      cnt_r      <= '0;
      qcnt_r     <= '0;
    end else begin
      qcnt_r <= qcnt_nxt;
      if (in_xfer) begin
        if (in_tlast) begin
          pos_r      <= '0;
          zrun_r     <= '0;
          open_r     <= 1'b0;
          open_off_r <= '0;
          open_len_r <= '0;
          cnt_r      <= '0;
        end else begin
          pos_r      <= pos_nxt;
          zrun_r     <= zrun_nxt;
          open_r     <= open_nxt;
          open_off_r <= open_off_nxt;
          open_len_r <= open_len_nxt;
          cnt_r      <= cnt_nxt;
        end
      end
    end
  end

  // Queue payload needs no reset
  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) q_r[i] <= q_nxt[i];
  end

  // Drive the descriptor stream from the queue head
  assign out_tvalid = (qcnt_r != '0);
  assign out_tdata  = {5'b0, q_r[0].nal_number, q_r[0].start_code_len,
                       q_r[0].nal_size, q_r[0].nal_offset};
  assign out_tuser  = {q_r[0].buffer_final, q_r[0].nal_valid};
  assign out_tlast  = q_r[0].run_last;

endmodule
